>>> rtl/gnbm_pkg.sv
// Constants and types shared by the Box-Muller Gaussian noise core.
`timescale 1ns / 1ps

package gnbm_pkg;

  // Width of each uniform code field on the input stream.
  localparam int FIELD_BITS = 16;
  localparam int SAMPLE_BITS = 20;
  localparam int SCALE_BITS = 16;
  localparam logic [SCALE_BITS-1:0] SCALE_RESET = 16'd4096;

  localparam int LOG_FRAC_BITS = 24;
  localparam int SQRT_BITS = 27;
  localparam int HORNER_STEPS = 4;

  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;
  localparam logic [31:0] TWO_PI_Q29 = 32'hC90FDAA2;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [30:0] Q30_EIGHTH = 31'h2000_0000;

  localparam logic [20:0] SAMPLE_MAX = 21'd524287;
  localparam logic [20:0] SAMPLE_MIN_MAG = 21'd524288;

  // Reciprocals for the exact divisions of the series terms: q / d equals
  // (q * RECIP) >> SHIFT for every q below 2^30.
  localparam logic [31:0] COS_RECIP [HORNER_STEPS] =
    '{32'd1227133514, 32'd1145324613, 32'd1431655766, 32'd1073741824};
  localparam int COS_SHIFT [HORNER_STEPS] = '{36, 35, 34, 31};
  localparam logic [31:0] SIN_RECIP [HORNER_STEPS] =
    '{32'd1908874354, 32'd1636178018, 32'd1717986919, 32'd1431655766};
  localparam int SIN_SHIFT [HORNER_STEPS] = '{37, 36, 35, 33};

  typedef struct packed {
    logic                          last;
    logic signed [SAMPLE_BITS-1:0] sample;
  } out_item_t;

endpackage

>>> rtl/gaussian_noise_box_muller_core.sv
// Box-Muller Gaussian noise core: log, square root and cosine pipelines feeding a scaled sample.
// Throughput: one item per cycle while the output buffer is not full; the log path
// (24 squaring stages, 27 root stages) sets depth.
// A two-entry output buffer lets input transfers continue while one result waits.
// rst is synchronous and active high; it clears the valid bits and the output buffer,
// and sets noise_scale to 1.0.
`timescale 1ns / 1ps

module gaussian_noise_box_muller_core
  import gnbm_pkg::*;
#(
  parameter int UNIFORM_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] uniform_radius, [31:16] uniform_angle
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [19:0] noise_sample, [23:20] zero
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int KW = (UNIFORM_BITS < FIELD_BITS) ? UNIFORM_BITS : FIELD_BITS;
  localparam int MW = KW + 1;
  localparam int EW = $clog2(MW);
  localparam int PSH = 32 - UNIFORM_BITS;
  localparam logic [29:0] LIM = 30'(UNIFORM_BITS) << 24;

  localparam int ST_X = 2;
  localparam int ST_L = ST_X + LOG_FRAC_BITS;
  localparam int ST_D = ST_L + 1;
  localparam int ST_R = ST_D + 1;
  localparam int ST_S = ST_R + SQRT_BITS;
  localparam int ST_Z = ST_S + 1;
  localparam int ST_V = ST_Z + 1;
  localparam int ST_PH = 2;
  localparam int ST_CX = 3;
  localparam int ST_T2 = 4;
  localparam int ST_C = ST_T2 + 2 * HORNER_STEPS + 1;

  logic en;
  logic [ST_V:1] vld;
  logic last_d [1:ST_V];

  logic [SCALE_BITS-1:0] noise_scale;

  // Log path registers.
  logic [MW-1:0] m1;
  logic [EW-1:0] le [1:ST_L];
  logic [30:0] lx [ST_X:ST_L];
  logic [23:0] lf [ST_X:ST_L];
  logic [29:0] dval;
  logic [53:0] qrem [ST_R:ST_S];
  logic [26:0] qroot [ST_R:ST_S];

  // Cosine path registers.
  logic [KW-1:0] ang1;
  logic [29:0] carg;
  logic [29:0] cx [ST_CX:ST_C-1];
  logic [29:0] ct2 [ST_T2:ST_C-1];
  logic [30:0] ch [ST_T2:ST_C-1];
  logic csin [ST_PH:ST_C-1];
  logic cneg [ST_PH:ST_V];
  logic [30:0] ccos [ST_C:ST_S];

  logic [27:0] zval;
  logic [43:0] vval;

  // Combinational next values.
  logic [MW-1:0] m_in;
  logic [EW-1:0] e_in;
  logic [61:0] lsq [LOG_FRAC_BITS];
  logic [30:0] lx_next [LOG_FRAC_BITS];
  logic [23:0] lf_next [LOG_FRAC_BITS];
  logic [EW+23:0] lval;
  logic [29:0] dval_next;
  logic [61:0] rprod;
  logic [54:0] trial [SQRT_BITS];
  logic [53:0] qrem_next [SQRT_BITS];
  logic [26:0] qroot_next [SQRT_BITS];
  logic [63:0] pwide;
  logic [31:0] phase;
  logic [30:0] uq;
  logic csin_next;
  logic [29:0] carg_next;
  logic [61:0] cxprod;
  logic [59:0] t2prod;
  logic [60:0] hprod [HORNER_STEPS];
  logic [62:0] rcprod [HORNER_STEPS];
  logic [30:0] hdiv [HORNER_STEPS];
  logic [60:0] finprod;
  logic [30:0] ccos_next;
  logic [57:0] zprod;
  logic [44:0] rnd;
  logic [20:0] mag;
  logic [20:0] mag_lim;
  out_item_t item_next;

  // Output buffer.
  out_item_t obuf [2];
  logic [1:0] ocnt;
  logic ord;
  logic owr;
  logic push;
  logic pop;

  assign en = (ocnt != 2'd2);
  assign s_axis_tready = en;
  assign cfg_ready = 1'b1;
  assign push = vld[ST_V] & en;
  assign pop = m_axis_tvalid & m_axis_tready;
  assign m_axis_tvalid = (ocnt != 2'd0);
  assign m_axis_tdata = {4'd0, obuf[ord].sample};
  assign m_axis_tlast = obuf[ord].last;

  always_comb begin
    // Leading-one search for the log normalisation.
    m_in = MW'(s_axis_tdata[KW-1:0]) + MW'(1);
    e_in = '0;
    for (int i = 0; i < MW; i++) begin
      if (m_in[i]) begin
        e_in = EW'(i);
      end
    end

    // Each squaring stage yields one fraction bit of log2.
    for (int j = 0; j < LOG_FRAC_BITS; j++) begin
      lsq[j] = 62'(lx[ST_X+j]) * 62'(lx[ST_X+j]);
      if (lsq[j][61]) begin
        lx_next[j] = lsq[j][61:31];
        lf_next[j] = lf[ST_X+j] | (24'(1) << (LOG_FRAC_BITS - 1 - j));
      end else begin
        lx_next[j] = lsq[j][60:30];
        lf_next[j] = lf[ST_X+j];
      end
    end

    lval = {le[ST_L], lf[ST_L]};
    dval_next = (30'(lval) > LIM) ? 30'd0 : LIM - 30'(lval);
    rprod = 62'(dval) * 62'(LN2_Q32);

    // Restoring square root, one result bit per stage.
    for (int i = 0; i < SQRT_BITS; i++) begin
      trial[i] = (55'(qroot[ST_R+i]) << (SQRT_BITS - i)) +
                 (55'(1) << (2 * (SQRT_BITS - 1 - i)));
      if (55'(qrem[ST_R+i]) >= trial[i]) begin
        qrem_next[i] = qrem[ST_R+i] - trial[i][53:0];
        qroot_next[i] = qroot[ST_R+i] | (27'(1) << (SQRT_BITS - 1 - i));
      end else begin
        qrem_next[i] = qrem[ST_R+i];
        qroot_next[i] = qroot[ST_R+i];
      end
    end

    // Fold the phase into the first eighth of a turn.
    pwide = 64'(ang1) << PSH;
    phase = pwide[31:0];
    uq = phase[30] ? (Q30_ONE - 31'(phase[29:0])) : 31'(phase[29:0]);
    csin_next = (uq > Q30_EIGHTH);
    carg_next = csin_next ? 30'(Q30_ONE - uq) : uq[29:0];

    cxprod = 62'(carg) * 62'(TWO_PI_Q29);
    t2prod = 60'(cx[ST_CX]) * 60'(cx[ST_CX]);

    for (int s = 0; s < HORNER_STEPS; s++) begin
      hprod[s] = 61'(ct2[ST_T2+2*s]) * 61'(ch[ST_T2+2*s]);
      if (csin[ST_T2+2*s+1]) begin
        rcprod[s] = 63'(ch[ST_T2+2*s+1]) * 63'(SIN_RECIP[s]);
        hdiv[s] = 31'(rcprod[s] >> SIN_SHIFT[s]);
      end else begin
        rcprod[s] = 63'(ch[ST_T2+2*s+1]) * 63'(COS_RECIP[s]);
        hdiv[s] = 31'(rcprod[s] >> COS_SHIFT[s]);
      end
    end

    finprod = 61'(cx[ST_C-1]) * 61'(ch[ST_C-1]);
    ccos_next = csin[ST_C-1] ? finprod[60:30] : ch[ST_C-1];

    zprod = 58'(qroot[ST_S]) * 58'(ccos[ST_S]);

    // Round the magnitude half away from zero, then saturate and apply the sign.
    rnd = 45'(vval) + (45'(1) << 23);
    mag = rnd[44:24];
    item_next.last = last_d[ST_V];
    if (mag == 21'd0) begin
      mag_lim = 21'd0;
      item_next.sample = '0;
    end else if (cneg[ST_V]) begin
      mag_lim = (mag > SAMPLE_MIN_MAG) ? SAMPLE_MIN_MAG : mag;
      item_next.sample = SAMPLE_BITS'(21'd0 - mag_lim);
    end else begin
      mag_lim = (mag > SAMPLE_MAX) ? SAMPLE_MAX : mag;
      item_next.sample = SAMPLE_BITS'(mag_lim);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      ocnt <= 2'd0;
      ord <= 1'b0;
      owr <= 1'b0;
      noise_scale <= SCALE_RESET;
    end else begin
      if (en) begin
        vld <= {vld[ST_V-1:1], s_axis_tvalid};
      end
      if (push) begin
        owr <= ~owr;
      end
      if (pop) begin
        ord <= ~ord;
      end
      ocnt <= ocnt + 2'(push) - 2'(pop);
      if (cfg_valid) begin
        noise_scale <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      obuf[owr] <= item_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last_d[1] <= s_axis_tlast;
      for (int i = 2; i <= ST_V; i++) begin
        last_d[i] <= last_d[i-1];
      end

      m1 <= m_in;
      le[1] <= e_in;
      ang1 <= s_axis_tdata[FIELD_BITS +: KW];

      le[ST_X] <= le[1];
      lx[ST_X] <= 31'(m1) << (5'd30 - 5'(le[1]));
      lf[ST_X] <= '0;
      for (int j = 0; j < LOG_FRAC_BITS; j++) begin
        le[ST_X+j+1] <= le[ST_X+j];
        lx[ST_X+j+1] <= lx_next[j];
        lf[ST_X+j+1] <= lf_next[j];
      end
      dval <= dval_next;
      qrem[ST_R] <= {rprod[60:31], 24'd0};
      qroot[ST_R] <= '0;
      for (int i = 0; i < SQRT_BITS; i++) begin
        qrem[ST_R+i+1] <= qrem_next[i];
        qroot[ST_R+i+1] <= qroot_next[i];
      end

      carg <= carg_next;
      csin[ST_PH] <= csin_next;
      cneg[ST_PH] <= phase[31] ^ phase[30];
      for (int i = ST_PH + 1; i <= ST_C - 1; i++) begin
        csin[i] <= csin[i-1];
      end
      for (int i = ST_PH + 1; i <= ST_V; i++) begin
        cneg[i] <= cneg[i-1];
      end
      cx[ST_CX] <= cxprod[60:31];
      for (int i = ST_CX + 1; i <= ST_C - 1; i++) begin
        cx[i] <= cx[i-1];
      end
      ct2[ST_T2] <= t2prod[59:30];
      ch[ST_T2] <= Q30_ONE;
      for (int i = ST_T2 + 1; i <= ST_C - 1; i++) begin
        ct2[i] <= ct2[i-1];
      end
      for (int s = 0; s < HORNER_STEPS; s++) begin
        ch[ST_T2+2*s+1] <= hprod[s][60:30];
        ch[ST_T2+2*s+2] <= Q30_ONE - hdiv[s];
      end
      ccos[ST_C] <= ccos_next;
      for (int i = ST_C + 1; i <= ST_S; i++) begin
        ccos[i] <= ccos[i-1];
      end

      zval <= zprod[57:30];
      vval <= 44'(zval) * 44'(noise_scale);
    end
  end

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    vld[ST_S] |-> (55'(qrem[ST_S]) <= (55'(qroot[ST_S]) << 1)))
    else $error("square root remainder out of range");

  a_cos_bound: assert property (@(posedge clk) disable iff (rst)
    vld[ST_C] |-> (ccos[ST_C] <= Q30_ONE))
    else $error("cosine magnitude above one");
`endif

endmodule
